@@ hw/rtl/hkr_pkg.sv @@
// Shared types and constants of the keyboard report state unit.
package hkr_pkg;

    // Report layout
    localparam int unsigned SlotFields = 6;
    localparam int unsigned KeyW       = 8;
    localparam logic [KeyW-1:0] ModCodeFirst = 8'd224;
    localparam logic [KeyW-1:0] ModCodeLast  = 8'd231;

    // Item operation codes
    localparam logic OpPress   = 1'b0;
    localparam logic OpRelease = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUSY      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic step;
        logic load_out;
        logic err;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic at_end;
        logic last;
    } t_sts;

endpackage

@@ hw/rtl/hkr_if.sv @@
// Valid/ready channel interfaces for key items and report results.
interface hkr_key_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] key_code;
    logic       last_in_batch;

    modport source (output valid, op, key_code, last_in_batch, input ready);
    modport sink   (input valid, op, key_code, last_in_batch, output ready);
endinterface

interface hkr_rpt_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] modifier_byte;
    logic [7:0] slot_key_0;
    logic [7:0] slot_key_1;
    logic [7:0] slot_key_2;
    logic [7:0] slot_key_3;
    logic [7:0] slot_key_4;
    logic [7:0] slot_key_5;

    modport source (output valid, status, modifier_byte, slot_key_0, slot_key_1,
                    slot_key_2, slot_key_3, slot_key_4, slot_key_5, input ready);
    modport sink   (input valid, status, modifier_byte, slot_key_0, slot_key_1,
                    slot_key_2, slot_key_3, slot_key_4, slot_key_5, output ready);
endinterface

@@ hw/rtl/hkr_ctrl.sv @@
// Controller state machine: item intake, slot search sequencing, result hand-off.
module hkr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  hkr_pkg::t_sts i_sts,
    output hkr_pkg::t_cmd o_cmd
);
    import hkr_pkg::*;

    t_state r_state, n_state;
    logic   r_skip, n_skip;
    logic   r_err, n_err;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    // Hold state and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_skip      <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_skip      <= n_skip;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_skip      = r_skip;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.err   = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_skip) begin
                        // drop the item, the marked last one ends skipping
                        n_skip = !i_in_last;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        n_state         = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.hit) begin
                    n_err   = 1'b0;
                    n_state = i_sts.last ? S_RESULT : S_IDLE;
                end else if (i_sts.at_end) begin
                    n_err   = 1'b1;
                    n_skip  = !i_sts.last;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // load the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/hkr_dp.sv @@
// Datapath: item register, modifier mask, key slots, slot search and result register.
module hkr_dp #(
    parameter int KEY_SLOTS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op,
    input  logic [7:0]    i_key_code,
    input  logic          i_last,
    input  hkr_pkg::t_cmd i_cmd,
    output hkr_pkg::t_sts o_sts,
    output logic [1:0]    o_status,
    output logic [7:0]    o_modifier,
    output logic [hkr_pkg::SlotFields-1:0][7:0] o_slots
);
    import hkr_pkg::*;

    localparam int IdxW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(KEY_SLOTS - 1);

    logic                r_op;
    logic [KeyW-1:0]     r_code;
    logic                r_last;
    logic [IdxW-1:0]     r_idx;
    logic [7:0]          r_mod;
    logic [KeyW-1:0]     r_slot [KEY_SLOTS];
    t_status             r_out_status;
    logic [7:0]          r_out_mod;
    logic [SlotFields-1:0][7:0] r_out_slots;

    logic                w_is_mod;
    logic [7:0]          w_mod_bit;
    logic [KeyW-1:0]     w_target;
    logic                w_hit;
    t_status             w_err_status;

    // Decode the latched item
    assign w_is_mod     = (r_code >= ModCodeFirst) && (r_code <= ModCodeLast);
    assign w_mod_bit    = 8'(1) << r_code[2:0];
    assign w_target     = (r_op == OpRelease) ? r_code : '0;
    assign w_hit        = w_is_mod || (r_slot[r_idx] == w_target);
    assign w_err_status = (r_op == OpRelease) ? ST_NOT_FOUND : ST_BUSY;

    assign o_sts.hit    = w_hit;
    assign o_sts.at_end = (r_idx == LastIdx);
    assign o_sts.last   = r_last;

    // Latch the item and advance the slot pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_code <= i_key_code;
            r_last <= i_last;
            r_idx  <= '0;
        end else if (i_cmd.step && !w_hit && !o_sts.at_end) begin
            r_idx  <= r_idx + 1'b1;
        end
    end

    // Update the report state on a hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= '0;
            for (int i = 0; i < KEY_SLOTS; i++) r_slot[i] <= '0;
        end else if (i_cmd.step && w_hit) begin
            if (w_is_mod) begin
                r_mod <= (r_op == OpRelease) ? (r_mod & ~w_mod_bit) : (r_mod | w_mod_bit);
            end else begin
                r_slot[r_idx] <= (r_op == OpRelease) ? '0 : r_code;
            end
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.err ? w_err_status : ST_OK;
            r_out_mod    <= r_mod;
            for (int i = 0; i < SlotFields; i++) begin
                r_out_slots[i] <= (i < KEY_SLOTS) ? r_slot[i] : '0;
            end
        end
    end

    assign o_status   = r_out_status;
    assign o_modifier = r_out_mod;
    assign o_slots    = r_out_slots;

endmodule

@@ hw/rtl/hid_keyboard_report_state_unit.sv @@
// Top level of the boot-keyboard report state unit.
// Keeps a modifier byte and KEY_SLOTS key slots (1..6). Each accepted item
// presses or releases one usage code; codes 224..231 set (press) or clear
// (release) one modifier bit, others fill the first empty slot or clear the
// first matching one. One result with status and the full report is offered
// at batch end or at the first error; the rest of an erroring batch is
// dropped. One item is worked at a time: a press or release passes through
// intake, a sequential slot search that compares one slot per cycle, and a
// result load only when a result is due; a dropped item is taken in the idle
// state and goes no further. The output register lets the next item enter
// while a result waits to be taken; a second result waits in the load step
// until the first one is taken.
module hid_keyboard_report_state_unit #(
    parameter int KEY_SLOTS = 6
) (
    input logic     i_clk,
    input logic     i_rst_n,
    hkr_key_if.sink   i_kb,
    hkr_rpt_if.source o_rpt
);
    import hkr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic [SlotFields-1:0][7:0] w_slots;

    hkr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_kb.valid),
        .i_in_last   (i_kb.last_in_batch),
        .o_in_ready  (i_kb.ready),
        .o_out_valid (o_rpt.valid),
        .i_out_ready (o_rpt.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hkr_dp #(.KEY_SLOTS(KEY_SLOTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (i_kb.op),
        .i_key_code (i_kb.key_code),
        .i_last     (i_kb.last_in_batch),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_status   (o_rpt.status),
        .o_modifier (o_rpt.modifier_byte),
        .o_slots    (w_slots)
    );

    // Spread the slots over the report fields
    assign o_rpt.slot_key_0 = w_slots[0];
    assign o_rpt.slot_key_1 = w_slots[1];
    assign o_rpt.slot_key_2 = w_slots[2];
    assign o_rpt.slot_key_3 = w_slots[3];
    assign o_rpt.slot_key_4 = w_slots[4];
    assign o_rpt.slot_key_5 = w_slots[5];

endmodule

@@ hw/rtl/hkr_checker.sv @@
// Port-level checks of the report state unit, bound to the top level.
module hkr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [7:0] i_modifier,
    input logic [7:0] i_slot_0
);
    import hkr_pkg::*;

    // A waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_modifier) && $stable(i_slot_0))
        else $error("result changed while stalled");

    // Status is a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_BUSY
            || i_status == ST_NOT_FOUND))
        else $error("undefined status code");

    // Reset empties the output
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

endmodule

bind hid_keyboard_report_state_unit hkr_checker u_hkr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rpt.valid),
    .i_out_ready (o_rpt.ready),
    .i_status    (o_rpt.status),
    .i_modifier  (o_rpt.modifier_byte),
    .i_slot_0    (o_rpt.slot_key_0)
);

@@ tb/hkr_report_checker.sv @@
// Report checker for the keyboard report state unit: predicts and compares each report.
module hkr_report_checker #(
    parameter int KEY_SLOTS = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hkr_key_if   i_kb,
    hkr_rpt_if   i_rpt,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_reports,
    output int   o_error_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    import hkr_pkg::*;

    typedef struct packed {
        t_status               status;
        logic [7:0]            modifier_byte;
        logic [5:0][KeyW-1:0]  slot_key;
    } t_report;

    // Predicted keyboard state
    logic [7:0]      mods_q;
    logic [KeyW-1:0] slots_q [6];
    logic            skip_batch_q;

    // Reports owed by the block, oldest first
    t_report reports_due [$];

    // Apply one key item to the predicted state; return 1 when a report is owed
    function automatic bit apply_key(input logic op, input logic [KeyW-1:0] code,
                                     input logic last, output t_report rep);
        t_status    st;
        logic       is_mod;
        logic [7:0] mbit;
        int         i;
        rep = '0;
        if (skip_batch_q) begin
            if (last) skip_batch_q = 1'b0;
            return 1'b0;
        end
        is_mod = (code >= ModCodeFirst) && (code <= ModCodeLast);
        mbit   = is_mod ? (8'd1 << (code - ModCodeFirst)) : 8'd0;
        st     = (op == OpPress) ? ST_BUSY : ST_NOT_FOUND;
        if (is_mod) begin
            if (op == OpPress) mods_q = mods_q | mbit;
            else mods_q = mods_q & ~mbit;
            st = ST_OK;
        end else begin
            // Search slots in order, first match wins
            for (i = 0; i < KEY_SLOTS; i++) begin
                if (st != ST_OK) begin
                    if (op == OpPress && slots_q[i] == '0) begin
                        slots_q[i] = code;
                        st = ST_OK;
                    end else if (op == OpRelease && slots_q[i] == code) begin
                        slots_q[i] = '0;
                        st = ST_OK;
                    end
                end
            end
        end
        if (st == ST_OK && !last) return 1'b0;
        if (st != ST_OK && !last) skip_batch_q = 1'b1;
        rep.status        = st;
        rep.modifier_byte = mods_q;
        for (i = 0; i < 6; i++) rep.slot_key[i] = (i < KEY_SLOTS) ? slots_q[i] : '0;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // Compare taken reports first, then predict from the accepted item
    always @(posedge i_clk) begin
        t_report rep;
        t_report want;
        t_report got;
        int      i;
        if (!i_rst_n) begin
            mods_q       = '0;
            skip_batch_q = 1'b0;
            for (i = 0; i < 6; i++) slots_q[i] = '0;
            reports_due.delete();
        end else begin
            if (i_rpt.valid && i_rpt.ready) begin
                got.status        = t_status'(i_rpt.status);
                got.modifier_byte = i_rpt.modifier_byte;
                got.slot_key[0]   = i_rpt.slot_key_0;
                got.slot_key[1]   = i_rpt.slot_key_1;
                got.slot_key[2]   = i_rpt.slot_key_2;
                got.slot_key[3]   = i_rpt.slot_key_3;
                got.slot_key[4]   = i_rpt.slot_key_4;
                got.slot_key[5]   = i_rpt.slot_key_5;
                if (reports_due.size() == 0) begin
                    $error("report with status %0d arrived while none was owed",
                           got.status);
                    o_fail_count++;
                end else begin
                    want = reports_due.pop_front();
                    o_reports++;
                    if (want.status != ST_OK) o_error_reports++;
                    check_field("status", want.status, got.status);
                    check_field("modifier_byte", want.modifier_byte, got.modifier_byte);
                    for (i = 0; i < 6; i++)
                        check_field($sformatf("slot_key_%0d", i), want.slot_key[i],
                                    got.slot_key[i]);
                end
            end
            if (i_kb.valid && i_kb.ready) begin
                if (apply_key(i_kb.op, i_kb.key_code, i_kb.last_in_batch, rep))
                    reports_due.push_back(rep);
            end
        end
        o_pending = reports_due.size();
    end

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_reports       = 0;
        o_error_reports = 0;
    end

endmodule

@@ tb/tb_hid_keyboard_report_state_unit.sv @@
// Top of the keyboard report state unit testbench: clock, reset, key stimulus, verdict.
module tb_hid_keyboard_report_state_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hkr_pkg::*;

    localparam int NumSlots    = 6;
    localparam int RandomItems = 750;
    localparam int QuietItems  = 100;

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   items_sent;
    int   batches_sent;
    int   fail_count;
    int   pending;
    int   reports;
    int   error_reports;

    hkr_key_if kb_ch ();
    hkr_rpt_if rpt_ch ();

    hid_keyboard_report_state_unit #(
        .KEY_SLOTS(NumSlots)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_kb   (kb_ch),
        .o_rpt  (rpt_ch)
    );

    hkr_report_checker #(
        .KEY_SLOTS(NumSlots)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kb           (kb_ch),
        .i_rpt          (rpt_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_reports      (reports),
        .o_error_reports(error_reports)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5ms;
        $display("tb_hid_keyboard_report_state_unit: errors");
        $finish;
    end

    // Report sink: ready with random stall bursts, always ready once quiet
    initial begin
        int stall_left;
        stall_left    = 0;
        rpt_ch.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                rpt_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rpt_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
            end
        end
    end

    // Drive one key item and hold it until the block takes it
    task automatic send_key(input logic op, input logic [KeyW-1:0] code, input logic last);
        @(negedge i_clk);
        kb_ch.valid         <= 1'b1;
        kb_ch.op            <= op;
        kb_ch.key_code      <= code;
        kb_ch.last_in_batch <= last;
        do @(posedge i_clk); while (!kb_ch.ready);
        items_sent++;
        if (last) batches_sent++;
    endtask

    // Drop valid for a random burst now and then
    task automatic maybe_idle();
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 19);
            repeat (n) begin
                @(negedge i_clk);
                kb_ch.valid <= 1'b0;
            end
        end
    endtask

    // Hold off until every owed report has been taken
    task automatic drain();
        @(negedge i_clk);
        kb_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic directed_key(input logic op, input logic [KeyW-1:0] code, input logic last);
        send_key(op, code, last);
        maybe_idle();
    endtask

    // Pick a key code: mostly modifiers and a small key pool so releases hit
    function automatic logic [KeyW-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return ModCodeFirst + KeyW'($urandom_range(0, 7));
        if (r < 84) return KeyW'($urandom_range(1, 9));
        if (r < 87) return '0;
        return KeyW'($urandom_range(0, 255));
    endfunction

    initial begin
        int          len;
        int          k;
        logic        op;
        bit          drained_mid;
        quiet               = 1'b0;
        drained_mid         = 1'b0;
        items_sent          = 0;
        batches_sent        = 0;
        i_rst_n             = 1'b0;
        kb_ch.valid         = 1'b0;
        kb_ch.op            = OpPress;
        kb_ch.key_code      = '0;
        kb_ch.last_in_batch = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: set two modifiers and fill all slots, then overflow and misses
        directed_key(OpPress,   8'd224, 1'b0);
        directed_key(OpPress,   8'd231, 1'b0);
        directed_key(OpPress,   8'd4,   1'b0);
        directed_key(OpPress,   8'd5,   1'b0);
        directed_key(OpPress,   8'd6,   1'b0);
        directed_key(OpPress,   8'd7,   1'b0);
        directed_key(OpPress,   8'd8,   1'b0);
        directed_key(OpPress,   8'd255, 1'b1);
        // Overflow mid batch: the rest of the batch is dropped
        directed_key(OpPress,   8'd10,  1'b0);
        directed_key(OpRelease, 8'd4,   1'b0);
        directed_key(OpPress,   8'd11,  1'b1);
        // Errors on the last item, including code zero with no empty slot
        directed_key(OpPress,   8'd0,   1'b1);
        directed_key(OpRelease, 8'd0,   1'b1);
        directed_key(OpRelease, 8'd200, 1'b1);
        // Code zero with a free slot: stored, then matched on release
        directed_key(OpRelease, 8'd5,   1'b0);
        directed_key(OpPress,   8'd0,   1'b0);
        directed_key(OpRelease, 8'd0,   1'b1);
        // Modifier edges and the codes just outside the modifier range
        directed_key(OpRelease, 8'd231, 1'b0);
        directed_key(OpRelease, 8'd230, 1'b0);
        directed_key(OpPress,   8'd223, 1'b0);
        directed_key(OpRelease, 8'd223, 1'b1);
        directed_key(OpRelease, 8'd224, 1'b1);
        directed_key(OpPress,   8'd232, 1'b1);
        directed_key(OpRelease, 8'd232, 1'b0);
        directed_key(OpRelease, 8'd6,   1'b1);
        drain();

        // Random batches of key events
        while (items_sent < RandomItems) begin
            if (items_sent >= RandomItems - QuietItems) quiet = 1'b1;
            if (!drained_mid && items_sent >= RandomItems / 2) begin
                drain();
                drained_mid = 1'b1;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
                op = ($urandom_range(0, 99) < 55) ? OpPress : OpRelease;
                send_key(op, pick_code(), k == len - 1);
                maybe_idle();
            end
        end

        // Wind down and give the verdict
        drain();
        repeat (20) @(negedge i_clk);
        $display("sent %0d key items in %0d batches; %0d reports checked, %0d with error status",
                 items_sent, batches_sent, reports, error_reports);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_hid_keyboard_report_state_unit: clean");
        end else begin
            $display("tb_hid_keyboard_report_state_unit: errors");
        end
        $finish;
    end

endmodule
